// ----- hdl/biquad_lowpass_filter_top_assert.svh -----
// assertion macros shared by the biquad low-pass filter rtl
`ifndef BIQUAD_LOWPASS_FILTER_TOP_ASSERT_SVH
`define BIQUAD_LOWPASS_FILTER_TOP_ASSERT_SVH

// clocked check, disabled while reset is asserted
`define BIQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// clocked check that also holds during reset
`define BIQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/biq_pkg.sv -----
// shared types, constants and saturation helpers for the biquad low-pass filter
package biq_pkg;

    localparam int SAMPLE_WIDTH   = 16;
    localparam int COEF_FRAC_BITS = 16;
    localparam int STATE_FRAC     = 8;
    localparam int STATE_WIDTH    = 32;

    localparam int B0_WIDTH   = COEF_FRAC_BITS + 1;
    localparam int COEF_WIDTH = COEF_FRAC_BITS + 2;

    // shared multiplier operand and product widths
    localparam int MUL_A_WIDTH = COEF_WIDTH;
    localparam int MUL_B_WIDTH = STATE_WIDTH + 3;
    localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;

    // feedback after rounding, output after rounding
    localparam int FBR_WIDTH = PROD_WIDTH - COEF_FRAC_BITS;
    localparam int RND_WIDTH = PROD_WIDTH - COEF_FRAC_BITS - STATE_FRAC;

    localparam int DATA_WIDTH = 32;
    localparam int ADDR_WIDTH = 4;

    // register map, word index
    typedef enum logic [1:0] {
        REG_B0     = 2'd0,
        REG_A1     = 2'd1,
        REG_A2     = 2'd2,
        REG_BYPASS = 2'd3
    } reg_idx_t;

    // configuration bundle from the register block to the datapath
    typedef struct packed {
        logic        [B0_WIDTH-1:0]   b0;
        logic signed [COEF_WIDTH-1:0] a1;
        logic signed [COEF_WIDTH-1:0] a2;
        logic                         bypass;
    } cfg_t;

    localparam logic signed [FBR_WIDTH-1:0] FBR_STATE_MAX =
        {{(FBR_WIDTH-STATE_WIDTH+1){1'b0}}, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [FBR_WIDTH-1:0] FBR_STATE_MIN =
        {{(FBR_WIDTH-STATE_WIDTH+1){1'b1}}, {(STATE_WIDTH-1){1'b0}}};
    localparam logic signed [RND_WIDTH-1:0] RND_SAMPLE_MAX =
        {{(RND_WIDTH-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [RND_WIDTH-1:0] RND_SAMPLE_MIN =
        {{(RND_WIDTH-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};

    // clamp a wide feedback value to a delay element
    function automatic logic signed [STATE_WIDTH-1:0] sat_state(
        input logic signed [FBR_WIDTH-1:0] v
    );
        logic signed [STATE_WIDTH-1:0] r;
        if (v > FBR_STATE_MAX)
            r = FBR_STATE_MAX[STATE_WIDTH-1:0];
        else if (v < FBR_STATE_MIN)
            r = FBR_STATE_MIN[STATE_WIDTH-1:0];
        else
            r = v[STATE_WIDTH-1:0];
        return r;
    endfunction

    // clamp a rounded output to the sample range
    function automatic logic signed [SAMPLE_WIDTH-1:0] sat_sample(
        input logic signed [RND_WIDTH-1:0] v
    );
        logic signed [SAMPLE_WIDTH-1:0] r;
        if (v > RND_SAMPLE_MAX)
            r = RND_SAMPLE_MAX[SAMPLE_WIDTH-1:0];
        else if (v < RND_SAMPLE_MIN)
            r = RND_SAMPLE_MIN[SAMPLE_WIDTH-1:0];
        else
            r = v[SAMPLE_WIDTH-1:0];
        return r;
    endfunction

endpackage

// ----- hdl/biq_apb_regs.sv -----
// apb register block holding the filter coefficients and bypass flag
module biq_apb_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [biq_pkg::ADDR_WIDTH-1:0]  paddr,
    input  logic [biq_pkg::DATA_WIDTH-1:0]  pwdata,
    output logic [biq_pkg::DATA_WIDTH-1:0]  prdata,
    output logic                            pready,
    output biq_pkg::cfg_t                   cfg
);
    import biq_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_WIDTH-1:2]);
    assign wr_en  = psel & penable & pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_B0:     cfg_next.b0     = pwdata[B0_WIDTH-1:0];
                REG_A1:     cfg_next.a1     = pwdata[COEF_WIDTH-1:0];
                REG_A2:     cfg_next.a2     = pwdata[COEF_WIDTH-1:0];
                REG_BYPASS: cfg_next.bypass = pwdata[0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.b0     <= '0;
            cfg_reg.a1     <= '0;
            cfg_reg.a2     <= '0;
            cfg_reg.bypass <= 1'b1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_B0:     prdata = DATA_WIDTH'(cfg_reg.b0);
            REG_A1:     prdata = DATA_WIDTH'(cfg_reg.a1);
            REG_A2:     prdata = DATA_WIDTH'(cfg_reg.a2);
            REG_BYPASS: prdata = DATA_WIDTH'(cfg_reg.bypass);
            default:    prdata = '0;
        endcase
    end

endmodule

// ----- hdl/biq_mul.sv -----
// shared signed multiplier with registered product
module biq_mul (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic signed [biq_pkg::MUL_A_WIDTH-1:0] a,
    input  logic signed [biq_pkg::MUL_B_WIDTH-1:0] b,
    output logic signed [biq_pkg::PROD_WIDTH-1:0]  prod
);
    import biq_pkg::*;

    logic signed [PROD_WIDTH-1:0] prod_reg;
    logic signed [PROD_WIDTH-1:0] prod_next;

    // full-precision product
    always_comb
    begin
        prod_next = PROD_WIDTH'(a) * PROD_WIDTH'(b);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

// ----- hdl/biquad_lowpass_filter_top.sv -----
// top level: apb registers, sequencer and datapath of the direct form ii biquad
// a filtered item passes seven sequencer steps after the accept cycle, and these share one
//   multiplier for the three products; a bypassed item goes from accept straight to output
// the sequencer takes no new item until the current one has been written out
// the output register lets the next item be taken while a result waits
// reset (async, active low) clears delay line and coefficients and sets bypass
module biquad_lowpass_filter_top (
    input  logic                                clk,
    input  logic                                rst_n,
    // tdata: sample_in [15:0]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [biq_pkg::SAMPLE_WIDTH-1:0]    s_tdata,
    // tdata: sample_out [15:0]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [biq_pkg::SAMPLE_WIDTH-1:0]    m_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [biq_pkg::ADDR_WIDTH-1:0]      paddr,
    input  logic [biq_pkg::DATA_WIDTH-1:0]      pwdata,
    output logic [biq_pkg::DATA_WIDTH-1:0]      prdata,
    output logic                                pready
);
    import biq_pkg::*;
    `include "biquad_lowpass_filter_top_assert.svh"

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_MUL_A1 = 8'b0000_0010,
        ST_MUL_A2 = 8'b0000_0100,
        ST_ACC    = 8'b0000_1000,
        ST_W0     = 8'b0001_0000,
        ST_SUM    = 8'b0010_0000,
        ST_MUL_B0 = 8'b0100_0000,
        ST_OUT    = 8'b1000_0000
    } state_t;

    localparam logic signed [PROD_WIDTH-1:0] FB_HALF  =
        PROD_WIDTH'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [PROD_WIDTH-1:0] OUT_HALF =
        PROD_WIDTH'(1) << (COEF_FRAC_BITS + STATE_FRAC - 1);

    cfg_t cfg;

    state_t                          state_reg, state_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic signed [STATE_WIDTH-1:0]   delay_one_reg, delay_one_next;
    logic signed [STATE_WIDTH-1:0]   delay_two_reg, delay_two_next;
    logic signed [SAMPLE_WIDTH-1:0]  m_tdata_reg, m_tdata_next;
    logic signed [SAMPLE_WIDTH-1:0]  x_reg, x_next;
    logic                            byp_reg, byp_next;
    logic signed [PROD_WIDTH-1:0]    acc_reg, acc_next;
    logic signed [FBR_WIDTH-1:0]     fbr_reg, fbr_next;
    logic signed [STATE_WIDTH-1:0]   w0_reg, w0_next;
    logic signed [MUL_B_WIDTH-1:0]   sum_reg, sum_next;

    logic                            mul_en;
    logic signed [MUL_A_WIDTH-1:0]   mul_a;
    logic signed [MUL_B_WIDTH-1:0]   mul_b;
    logic signed [PROD_WIDTH-1:0]    prod;

    logic signed [PROD_WIDTH-1:0]    fb_sum;
    logic signed [PROD_WIDTH-1:0]    out_sum;
    logic signed [FBR_WIDTH-1:0]     x_scaled;
    logic signed [FBR_WIDTH-1:0]     w0_wide;
    logic signed [MUL_B_WIDTH-1:0]   w0_ext, d1_ext, d2_ext;
    logic signed [RND_WIDTH-1:0]     y_rnd;

    biq_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    biq_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // widened operands
    assign w0_ext = {{(MUL_B_WIDTH-STATE_WIDTH){w0_reg[STATE_WIDTH-1]}}, w0_reg};
    assign d1_ext = {{(MUL_B_WIDTH-STATE_WIDTH){delay_one_reg[STATE_WIDTH-1]}},
                     delay_one_reg};
    assign d2_ext = {{(MUL_B_WIDTH-STATE_WIDTH){delay_two_reg[STATE_WIDTH-1]}},
                     delay_two_reg};
    assign x_scaled = {{(FBR_WIDTH-SAMPLE_WIDTH-STATE_FRAC){x_reg[SAMPLE_WIDTH-1]}},
                       x_reg, {STATE_FRAC{1'b0}}};

    // rounded feedback and rounded output
    assign fb_sum  = acc_reg + prod + FB_HALF;
    assign w0_wide = x_scaled - fbr_reg;
    assign out_sum = prod + OUT_HALF;
    assign y_rnd   = out_sum[PROD_WIDTH-1:COEF_FRAC_BITS+STATE_FRAC];

    // sequencer and datapath next state
    always_comb
    begin
        state_next     = state_reg;
        m_tvalid_next  = m_tvalid_reg;
        delay_one_next = delay_one_reg;
        delay_two_next = delay_two_reg;
        m_tdata_next   = m_tdata_reg;
        x_next         = x_reg;
        byp_next       = byp_reg;
        acc_next       = acc_reg;
        fbr_next       = fbr_reg;
        w0_next        = w0_reg;
        sum_next       = sum_reg;
        mul_en         = 1'b0;
        mul_a          = '0;
        mul_b          = '0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    x_next     = s_tdata;
                    byp_next   = cfg.bypass;
                    state_next = cfg.bypass ? ST_OUT : ST_MUL_A1;
                end
            end
            ST_MUL_A1:
            begin
                mul_en     = 1'b1;
                mul_a      = cfg.a1;
                mul_b      = d1_ext;
                state_next = ST_MUL_A2;
            end
            ST_MUL_A2:
            begin
                mul_en     = 1'b1;
                mul_a      = cfg.a2;
                mul_b      = d2_ext;
                acc_next   = prod;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                fbr_next   = fb_sum[PROD_WIDTH-1:COEF_FRAC_BITS];
                state_next = ST_W0;
            end
            ST_W0:
            begin
                w0_next    = sat_state(w0_wide);
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                sum_next   = w0_ext + (d1_ext <<< 1) + d2_ext;
                state_next = ST_MUL_B0;
            end
            ST_MUL_B0:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_A_WIDTH'(cfg.b0);
                mul_b      = sum_reg;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // load the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = byp_reg ? x_reg : sat_sample(y_rnd);
                    if (!byp_reg)
                    begin
                        delay_two_next = delay_one_reg;
                        delay_one_next = w0_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state and delay line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_tvalid_reg  <= 1'b0;
            delay_one_reg <= '0;
            delay_two_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            m_tvalid_reg  <= m_tvalid_next;
            delay_one_reg <= delay_one_next;
            delay_two_reg <= delay_two_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        x_reg       <= x_next;
        byp_reg     <= byp_next;
        acc_reg     <= acc_next;
        fbr_reg     <= fbr_next;
        w0_reg      <= w0_next;
        sum_reg     <= sum_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // a filtered item reaches the output stage after the fixed sequence
    `BIQ_ASSERT(a_filt_seq_len, clk, rst_n, (s_tvalid && s_tready && !cfg.bypass) |-> ##7 (state_reg == ST_OUT), "filtered item did not reach output stage in 7 cycles")
    // a bypassed item goes straight to the output stage
    `BIQ_ASSERT(a_byp_seq_len, clk, rst_n, (s_tvalid && s_tready && cfg.bypass) |=> (state_reg == ST_OUT), "bypassed item did not go to output stage")
    // the delay line moves only when a result is written out
    `BIQ_ASSERT(a_delay_hold, clk, rst_n, (state_reg != ST_OUT) |=> ($stable(delay_one_reg) && $stable(delay_two_reg)), "delay line changed outside output stage")
    // a result appears only from the output stage
    `BIQ_ASSERT(a_out_src, clk, rst_n, $rose(m_tvalid_reg) |-> ($past(state_reg) == ST_OUT), "output valid rose outside output stage")
    // the input side is never ready while the sequencer is busy
    `BIQ_ASSERT_ALWAYS(a_ready_idle, clk, (s_tready |-> (state_reg == ST_IDLE)), "input ready while sequencer busy")

endmodule

// ----- bench/biquad_response_checker.sv -----
// checker for the biquad low-pass filter: tracks register writes, predicts and compares output samples
module biquad_response_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [biq_pkg::SAMPLE_WIDTH-1:0] s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [biq_pkg::SAMPLE_WIDTH-1:0] m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [biq_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [biq_pkg::DATA_WIDTH-1:0]   pwdata,
    input  logic                             pready,
    output int                               errors,
    output int                               pending,
    output int                               samples_taken,
    output int                               results_checked
);
    timeunit 1ns;
    timeprecision 1ps;
    import biq_pkg::*;

    localparam longint STATE_HI = (longint'(1) <<< (STATE_WIDTH - 1)) - 1;
    localparam longint STATE_LO = -STATE_HI - 1;
    localparam longint OUT_HI   = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
    localparam longint OUT_LO   = -OUT_HI - 1;
    localparam longint FB_HALF  = longint'(1) <<< (COEF_FRAC_BITS - 1);
    localparam longint OUT_HALF = longint'(1) <<< (COEF_FRAC_BITS + STATE_FRAC - 1);

    // shadow copy of the coefficient registers
    logic        [B0_WIDTH-1:0]    gain_b0;
    logic signed [COEF_WIDTH-1:0]  fb_a1;
    logic signed [COEF_WIDTH-1:0]  fb_a2;
    logic                          pass_through;

    // shadow delay line, w1 and w2 with extra fraction bits
    logic signed [STATE_WIDTH-1:0] delay_w1;
    logic signed [STATE_WIDTH-1:0] delay_w2;

    logic signed [SAMPLE_WIDTH-1:0] expected_out[$];
    logic signed [SAMPLE_WIDTH-1:0] want;

    initial begin
        errors          = 0;
        pending         = 0;
        samples_taken   = 0;
        results_checked = 0;
    end

    // one direct form ii step: feedback, feedforward, then delay line shift; bypass returns x unchanged
    function automatic logic signed [SAMPLE_WIDTH-1:0] filter_step(
        input logic signed [SAMPLE_WIDTH-1:0] x
    );
        longint fb;
        longint w0;
        longint acc;
        longint y;
        if (pass_through)
            return x;
        fb = longint'(fb_a1) * longint'(delay_w1) + longint'(fb_a2) * longint'(delay_w2);
        w0 = (longint'(x) <<< STATE_FRAC) - ((fb + FB_HALF) >>> COEF_FRAC_BITS);
        if (w0 > STATE_HI)
            w0 = STATE_HI;
        else if (w0 < STATE_LO)
            w0 = STATE_LO;
        acc = w0 + 2 * longint'(delay_w1) + longint'(delay_w2);
        y = (longint'(gain_b0) * acc + OUT_HALF) >>> (COEF_FRAC_BITS + STATE_FRAC);
        if (y > OUT_HI)
            y = OUT_HI;
        else if (y < OUT_LO)
            y = OUT_LO;
        delay_w2 = delay_w1;
        delay_w1 = w0[STATE_WIDTH-1:0];
        return y[SAMPLE_WIDTH-1:0];
    endfunction

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            gain_b0      = '0;
            fb_a1        = '0;
            fb_a2        = '0;
            pass_through = 1'b1;
            delay_w1     = '0;
            delay_w2     = '0;
            expected_out.delete();
            pending      = 0;
        end
        else begin
            // register write at the access cycle
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[ADDR_WIDTH-1:2]))
                    REG_B0:     gain_b0      = pwdata[B0_WIDTH-1:0];
                    REG_A1:     fb_a1        = pwdata[COEF_WIDTH-1:0];
                    REG_A2:     fb_a2        = pwdata[COEF_WIDTH-1:0];
                    REG_BYPASS: pass_through = pwdata[0];
                    default:    ;
                endcase
            end

            // accepted input item
            if (s_tvalid && s_tready) begin
                expected_out.push_back(filter_step(s_tdata));
                samples_taken++;
            end

            // accepted output item
            if (m_tvalid && m_tready) begin
                if (expected_out.size() == 0) begin
                    errors++;
                    $display("%0t: sample_out %0d arrived with nothing expected",
                             $realtime, $signed(m_tdata));
                end
                else begin
                    want = expected_out.pop_front();
                    results_checked++;
                    if (m_tdata !== want) begin
                        errors++;
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $realtime, want, $signed(m_tdata));
                    end
                end
            end
            pending = expected_out.size();
        end
    end

endmodule

// ----- bench/tb_biquad_lowpass_filter_top.sv -----
// testbench top for the biquad low-pass filter: stimulus, register setup and verdict
module tb_biquad_lowpass_filter_top;
    timeunit 1ns;
    timeprecision 1ps;
    import biq_pkg::*;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [SAMPLE_WIDTH-1:0] s_tdata;   // sample_in [15:0]
    logic                    m_tvalid;
    logic                    m_tready;
    logic [SAMPLE_WIDTH-1:0] m_tdata;   // sample_out [15:0]
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [ADDR_WIDTH-1:0]   paddr;
    logic [DATA_WIDTH-1:0]   pwdata;
    logic [DATA_WIDTH-1:0]   prdata;
    logic                    pready;

    int errors;
    int pending;
    int samples_taken;
    int results_checked;

    // receiver and sender controls, set by the stimulus process
    int rx_hold  = 0;
    bit tx_burst = 1'b0;
    int settings_used = 0;

    // butterworth sections in q2.16: cutoff at a tenth and a quarter of the sample rate
    localparam logic        [B0_WIDTH-1:0]   BW10_B0 = 17'd4421;
    localparam logic signed [COEF_WIDTH-1:0] BW10_A1 = -18'sd74907;
    localparam logic signed [COEF_WIDTH-1:0] BW10_A2 = 18'sd27053;
    localparam logic        [B0_WIDTH-1:0]   BW4_B0  = 17'd19195;
    localparam logic signed [COEF_WIDTH-1:0] BW4_A2  = 18'sd11247;

    localparam logic [15:0] PASS_PROBE [8] = '{
        16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h8001
    };
    // impulse, negative full-scale step, positive full-scale step, small values
    localparam logic [15:0] STEP_PROBE [18] = '{
        16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000,
        16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
        16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
        16'h0001, 16'hFFFF
    };

    biquad_lowpass_filter_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    biquad_response_checker checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .errors          (errors),
        .pending         (pending),
        .samples_taken   (samples_taken),
        .results_checked (results_checked)
    );

    always #10 clk = ~clk;

    // run limit
    initial begin
        #5_000_000;
        $display("tb_biquad_lowpass_filter_top: errors");
        $finish;
    end

    // mix of full-range, small and near full-scale samples
    function automatic logic [15:0] pick_sample();
        logic [15:0] v;
        case ($urandom_range(0, 3))
            0, 1: v = 16'($urandom);
            2:    v = 16'($signed($urandom_range(0, 511)) - 256);
            default: v = $urandom_range(0, 1) ? 16'h7FFF - 16'($urandom_range(0, 7))
                                              : 16'h8000 + 16'($urandom_range(0, 7));
        endcase
        return v;
    endfunction

    // present one item after an optional gap, return at the accepting edge
    task automatic send_sample(input logic [15:0] value, input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do @(posedge clk); while (!s_tready);
    endtask

    // wait until every predicted sample has come out
    task automatic drain_results();
        @(negedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    // apb write: setup cycle, access cycle, then psel and penable dropped back to idle
    task automatic apb_write(input reg_idx_t idx, input logic [DATA_WIDTH-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_filter(
        input logic        [B0_WIDTH-1:0]   b0,
        input logic signed [COEF_WIDTH-1:0] a1,
        input logic signed [COEF_WIDTH-1:0] a2,
        input logic                         byp
    );
        apb_write(REG_B0, DATA_WIDTH'(b0));
        apb_write(REG_A1, DATA_WIDTH'(a1));
        apb_write(REG_A2, DATA_WIDTH'(a2));
        apb_write(REG_BYPASS, DATA_WIDTH'(byp));
        settings_used++;
    endtask

    // random samples with a full drain halfway through and at the end
    task automatic run_random(input int count, input bit squeeze);
        if (squeeze)
            rx_hold = 250;
        for (int i = 0; i < count; i++) begin
            if (i % 40 == 0)
                tx_burst = (squeeze && i == 0) || ($urandom_range(0, 3) == 0);
            if (i == count / 2) begin
                s_tvalid <= 1'b0;
                drain_results();
            end
            send_sample(pick_sample(), tx_burst ? 0 : $urandom_range(0, 13));
        end
        s_tvalid <= 1'b0;
        drain_results();
    endtask

    // receiver: random stalls, bursts without stalls, and a long hold on request
    initial begin
        int gap;
        int taken;
        bit rx_burst;
        taken    = 0;
        rx_burst = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (taken % 40 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (rx_hold > 0) begin
                gap     = rx_hold;
                rx_hold = 0;
            end
            else
                gap = rx_burst ? 0 : $urandom_range(0, 13);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            taken++;
        end
    end

    // stimulus and verdict
    initial begin
        int waited;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // pass-through out of reset
        foreach (PASS_PROBE[i])
            send_sample(PASS_PROBE[i], $urandom_range(0, 13));
        s_tvalid <= 1'b0;
        drain_results();

        // impulse and full-scale steps through a stable filter
        set_filter(BW10_B0, BW10_A1, BW10_A2, 1'b0);
        foreach (STEP_PROBE[i])
            send_sample(STEP_PROBE[i], $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 13));
        s_tvalid <= 1'b0;
        drain_results();

        // random phases over several coefficient settings
        for (int phase = 0; phase < 8; phase++) begin
            case (phase)
                0: set_filter(BW10_B0, BW10_A1, BW10_A2, 1'b0);
                // extreme gains, diverging feedback held by saturation
                1: set_filter(17'd65536, -18'sd131072, 18'sd65536, 1'b0);
                2: set_filter(17'd0, 18'sd131071, -18'sd65536, 1'b0);
                // bypass with the delay line left as it was
                3: set_filter(17'($urandom), 18'($urandom), 18'($urandom), 1'b1);
                // out-of-range gain and arbitrary feedback patterns
                4: set_filter(17'h1FFFF, 18'($urandom), 18'($urandom), 1'b0);
                5: set_filter(17'($urandom), 18'($urandom), 18'($urandom), 1'b0);
                6: set_filter(BW4_B0, 18'sd0, BW4_A2, 1'b0);
                default: set_filter(BW10_B0, BW10_A1, BW10_A2, 1'b0);
            endcase
            run_random(90, phase == 0);
        end

        // let any stray output show up
        waited = 0;
        while (pending != 0 && waited < 2000) begin
            @(posedge clk);
            waited++;
        end
        repeat (20) @(posedge clk);

        $display("covered %0d samples under %0d register settings, %0d outputs compared",
                 samples_taken, settings_used + 1, results_checked);
        $display("settings included bypass, full-scale steps, saturating and unstable feedback");
        if (errors == 0 && pending == 0)
            $display("tb_biquad_lowpass_filter_top: clean");
        else
            $display("tb_biquad_lowpass_filter_top: errors");
        $finish;
    end

endmodule
